// ===== rtl/core/rte_pkg.sv =====
// Shared types, widths and codes for the render tile enumerator.
// No dependencies; every other file of the block uses it.
`default_nettype none

package rte_pkg;

    localparam int COORD_W    = 15;
    localparam int TSIZE_W    = 13;
    localparam int LEFT_W     = 15;
    localparam int RIGHT_W    = 16;
    localparam int MAX_RES    = 16384;
    localparam int ID_W       = 28;
    localparam int CNT_W      = 29;
    localparam int OP_W       = 2;
    localparam int DIVD_W     = 28;
    localparam int DIVS_W     = 15;
    localparam int DIV_CNT_W  = $clog2(DIVD_W + 1);
    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 16;

    localparam logic [OP_W-1:0] OP_NEXT   = 2'd0;
    localparam logic [OP_W-1:0] OP_INDEX  = 2'd1;
    localparam logic [OP_W-1:0] OP_REWIND = 2'd2;

    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_WIDTH   = 3'd0;
    localparam logic [CFG_ADDR_W-1:0] REG_IMAGE_HEIGHT  = 3'd1;
    localparam logic [CFG_ADDR_W-1:0] REG_TILE_WIDTH    = 3'd2;
    localparam logic [CFG_ADDR_W-1:0] REG_TILE_HEIGHT   = 3'd3;
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_LEFT   = 3'd4;
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_TOP    = 3'd5;
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_RIGHT  = 3'd6;
    localparam logic [CFG_ADDR_W-1:0] REG_REGION_BOTTOM = 3'd7;

    typedef struct packed {
        logic [COORD_W-1:0] lo;
        logic [COORD_W-1:0] hi;
    } axis_span_t;

endpackage

`default_nettype wire

// ===== rtl/core/rte_div.sv =====
// Radix-2 restoring divider, one quotient bit per cycle.
// Depends on rte_pkg for widths.
`default_nettype none

module rte_div (
    input  wire logic                         clk,
    input  wire logic                         rst_n,
    input  wire logic                         start,
    input  wire logic [rte_pkg::DIVD_W-1:0]   dividend,
    input  wire logic [rte_pkg::DIVS_W-1:0]   divisor,
    output logic                              done,
    output logic [rte_pkg::DIVD_W-1:0]        quot,
    output logic [rte_pkg::DIVS_W-1:0]        rem
);

    logic                             busy_reg, busy_next;
    logic                             done_reg, done_next;
    logic [rte_pkg::DIV_CNT_W-1:0]    cnt_reg, cnt_next;
    logic [rte_pkg::DIVD_W-1:0]       q_reg, q_next;
    logic [rte_pkg::DIVS_W-1:0]       r_reg, r_next;
    logic [rte_pkg::DIVS_W-1:0]       d_reg, d_next;
    logic [rte_pkg::DIVS_W:0]         shifted;
    logic [rte_pkg::DIVS_W:0]         diff;
    logic                             fits;

    assign shifted = {r_reg, q_reg[rte_pkg::DIVD_W-1]};
    assign diff    = shifted - {1'b0, d_reg};
    assign fits    = shifted >= {1'b0, d_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        q_next    = q_reg;
        r_next    = r_reg;
        d_next    = d_reg;
        if (start)
        begin
            busy_next = 1'b1;
            cnt_next  = rte_pkg::DIV_CNT_W'(rte_pkg::DIVD_W);
            q_next    = dividend;
            r_next    = '0;
            d_next    = divisor;
        end
        else if (busy_reg)
        begin
            q_next   = {q_reg[rte_pkg::DIVD_W-2:0], fits};
            r_next   = fits ? diff[rte_pkg::DIVS_W-1:0] : shifted[rte_pkg::DIVS_W-1:0];
            cnt_next = cnt_reg - 1'b1;
            if (cnt_reg == rte_pkg::DIV_CNT_W'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        q_reg <= q_next;
        r_reg <= r_next;
        d_reg <= d_next;
    end

    assign done = done_reg;
    assign quot = q_reg;
    assign rem  = r_reg;

endmodule

`default_nettype wire

// ===== rtl/core/rte_axis.sv =====
// Per-axis region clamp: effective tile size and the covered pixel span.
// Depends on rte_pkg for widths and the axis_span_t type.
`default_nettype none

module rte_axis (
    input  wire logic        [rte_pkg::COORD_W-1:0]  res,
    input  wire logic        [rte_pkg::TSIZE_W-1:0]  tsize_raw,
    input  wire logic signed [rte_pkg::LEFT_W-1:0]   rmin,
    input  wire logic signed [rte_pkg::RIGHT_W-1:0]  rmax,
    output logic             [rte_pkg::TSIZE_W-1:0]  tsize,
    output rte_pkg::axis_span_t                      span
);

    localparam logic [rte_pkg::COORD_W-1:0] RES_LIMIT = rte_pkg::COORD_W'(rte_pkg::MAX_RES);

    logic        [rte_pkg::COORD_W-1:0]   res_c;
    logic        [rte_pkg::COORD_W-1:0]   lo_c;
    logic signed [rte_pkg::RIGHT_W+1:0]   res_s;
    logic signed [rte_pkg::RIGHT_W+1:0]   rmax_s;
    logic signed [rte_pkg::RIGHT_W+1:0]   hi_s;
    logic signed [rte_pkg::RIGHT_W+1:0]   lo_s;

    always_comb
    begin
        tsize  = (tsize_raw == '0) ? rte_pkg::TSIZE_W'(1) : tsize_raw;
        res_c  = (res > RES_LIMIT) ? RES_LIMIT : res;
        lo_c   = rmin[rte_pkg::LEFT_W-1] ? '0 : rte_pkg::COORD_W'(rmin);
        res_s  = $signed({3'b000, res_c});
        rmax_s = (rte_pkg::RIGHT_W+2)'(rmax);
        lo_s   = $signed({3'b000, lo_c});
        hi_s   = (rmax_s < res_s) ? rmax_s : res_s;
        if (hi_s <= lo_s)
        begin
            span.lo = '0;
            span.hi = '0;
        end
        else
        begin
            span.lo = lo_c;
            span.hi = hi_s[rte_pkg::COORD_W-1:0];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/render_tile_enumerator.sv =====
// Render tile enumerator: one request in, one tile descriptor out.
// A found tile takes one pass through the shared divider;
// misses, rewinds and unused ops skip it. The first request after
// reset or a register write also runs four grid divisions first.
// Reset clears the cursor and restores the default registers. Uses rte_pkg.
`default_nettype none

module render_tile_enumerator (
    input  wire logic                               clk,
    input  wire logic                               rst_n,
    input  wire logic                               cfg_we,
    input  wire logic [rte_pkg::CFG_ADDR_W-1:0]     cfg_addr,
    input  wire logic [rte_pkg::CFG_DATA_W-1:0]     cfg_data,
    input  wire logic                               s_axis_tvalid,
    output logic                                    s_axis_tready,
    input  wire logic [31:0]                        s_axis_tdata,  // tile_index
    input  wire logic [1:0]                         s_axis_tuser,  // op
    output logic                                    m_axis_tvalid,
    input  wire logic                               m_axis_tready,
    // tile_id, tile_left, tile_top, tile_right, tile_bottom, tile_count
    output logic [119:0]                            m_axis_tdata,
    output logic                                    m_axis_tuser   // found
);

    typedef enum logic [9:0] {
        S_IDLE      = 10'b0000000001,
        S_CFG_GO    = 10'b0000000010,
        S_CFG_WAIT  = 10'b0000000100,
        S_TOTAL     = 10'b0000001000,
        S_DISPATCH  = 10'b0000010000,
        S_IDX_GO    = 10'b0000100000,
        S_IDX_WAIT  = 10'b0001000000,
        S_MUL_X     = 10'b0010000000,
        S_MUL_Y     = 10'b0100000000,
        S_OUT       = 10'b1000000000
    } state_t;

    localparam int CW = rte_pkg::COORD_W;
    localparam int TW = rte_pkg::TSIZE_W;

    state_t state_reg, state_next;

    logic        [CW-1:0]                   image_width_reg;
    logic        [CW-1:0]                   image_height_reg;
    logic        [TW-1:0]                   tile_width_reg;
    logic        [TW-1:0]                   tile_height_reg;
    logic signed [rte_pkg::LEFT_W-1:0]      region_left_reg;
    logic signed [rte_pkg::LEFT_W-1:0]      region_top_reg;
    logic signed [rte_pkg::RIGHT_W-1:0]     region_right_reg;
    logic signed [rte_pkg::RIGHT_W-1:0]     region_bottom_reg;

    logic                                   dirty_reg;
    logic [rte_pkg::CNT_W-1:0]              cursor_reg;
    logic [1:0]                             step_reg;
    logic [rte_pkg::OP_W-1:0]               op_reg;
    logic [rte_pkg::ID_W-1:0]               index_reg;
    logic [rte_pkg::ID_W-1:0]               id_reg;
    logic                                   hit_reg;
    logic [CW-1:0]                          first_col_reg;
    logic [CW-1:0]                          first_row_reg;
    logic [CW-1:0]                          col_count_reg;
    logic [CW-1:0]                          row_count_reg;
    logic [rte_pkg::CNT_W-1:0]              total_reg;
    logic [CW-1:0]                          cx_reg;
    logic [CW-1:0]                          cy_reg;
    logic [CW-1:0]                          lraw_reg;
    logic [CW-1:0]                          traw_reg;

    logic                                   out_valid_reg;
    logic                                   out_found_reg;
    logic [119:0]                           out_data_reg;

    logic [TW-1:0]                          tw;
    logic [TW-1:0]                          th;
    rte_pkg::axis_span_t                    span_x;
    rte_pkg::axis_span_t                    span_y;

    logic                                   div_start;
    logic                                   div_done;
    logic [rte_pkg::DIVD_W-1:0]             div_dividend;
    logic [rte_pkg::DIVS_W-1:0]             div_divisor;
    logic [rte_pkg::DIVD_W-1:0]             div_quot;
    logic [rte_pkg::DIVS_W-1:0]             div_rem;

    logic [CW-1:0]                          mul_a;
    logic [CW-1:0]                          mul_b;
    logic [2*CW-1:0]                        mul_p;

    logic                                   in_fire;
    logic                                   out_load;
    logic [CW-1:0]                          clip_l;
    logic [CW-1:0]                          clip_t;
    logic [CW-1:0]                          clip_r;
    logic [CW-1:0]                          clip_b;
    logic [CW:0]                            sum_r;
    logic [CW:0]                            sum_b;
    logic [rte_pkg::ID_W-1:0]               res_id;

    rte_axis u_axis_x (
        .res       (image_width_reg),
        .tsize_raw (tile_width_reg),
        .rmin      (region_left_reg),
        .rmax      (region_right_reg),
        .tsize     (tw),
        .span      (span_x)
    );

    rte_axis u_axis_y (
        .res       (image_height_reg),
        .tsize_raw (tile_height_reg),
        .rmin      (region_top_reg),
        .rmax      (region_bottom_reg),
        .tsize     (th),
        .span      (span_y)
    );

    rte_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .done     (div_done),
        .quot     (div_quot),
        .rem      (div_rem)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign out_load      = (state_reg == S_OUT) && (!out_valid_reg || m_axis_tready);
    assign div_start     = (state_reg == S_CFG_GO) || (state_reg == S_IDX_GO);

    // Divider operand select
    always_comb
    begin
        div_dividend = id_reg;
        div_divisor  = col_count_reg;
        if (state_reg == S_CFG_GO)
        begin
            case (step_reg)
                2'd0:
                begin
                    div_dividend = rte_pkg::DIVD_W'(span_x.lo);
                    div_divisor  = rte_pkg::DIVS_W'(tw);
                end
                2'd1:
                begin
                    div_dividend = rte_pkg::DIVD_W'({1'b0, span_x.hi} + (CW+1)'(tw) - 1'b1);
                    div_divisor  = rte_pkg::DIVS_W'(tw);
                end
                2'd2:
                begin
                    div_dividend = rte_pkg::DIVD_W'(span_y.lo);
                    div_divisor  = rte_pkg::DIVS_W'(th);
                end
                default:
                begin
                    div_dividend = rte_pkg::DIVD_W'({1'b0, span_y.hi} + (CW+1)'(th) - 1'b1);
                    div_divisor  = rte_pkg::DIVS_W'(th);
                end
            endcase
        end
    end

    // Shared multiplier operand select
    always_comb
    begin
        mul_a = col_count_reg;
        mul_b = row_count_reg;
        if (state_reg == S_MUL_X)
        begin
            mul_a = cx_reg;
            mul_b = CW'(tw);
        end
        else if (state_reg == S_MUL_Y)
        begin
            mul_a = cy_reg;
            mul_b = CW'(th);
        end
    end

    assign mul_p = mul_a * mul_b;

    // Clip tile bounds to the region; all zero on a miss
    always_comb
    begin
        sum_r  = {1'b0, lraw_reg} + (CW+1)'(tw);
        sum_b  = {1'b0, traw_reg} + (CW+1)'(th);
        clip_l = (lraw_reg < span_x.lo) ? span_x.lo : lraw_reg;
        clip_t = (traw_reg < span_y.lo) ? span_y.lo : traw_reg;
        clip_r = (sum_r > {1'b0, span_x.hi}) ? span_x.hi : sum_r[CW-1:0];
        clip_b = (sum_b > {1'b0, span_y.hi}) ? span_y.hi : sum_b[CW-1:0];
        if (!hit_reg)
        begin
            clip_l = '0;
            clip_t = '0;
            clip_r = '0;
            clip_b = '0;
        end
        res_id = hit_reg ? id_reg : '0;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            S_IDLE:
                if (in_fire)
                    state_next = dirty_reg ? S_CFG_GO : S_DISPATCH;
            S_CFG_GO:
                state_next = S_CFG_WAIT;
            S_CFG_WAIT:
                if (div_done)
                    state_next = (step_reg == 2'd3) ? S_TOTAL : S_CFG_GO;
            S_TOTAL:
                state_next = S_DISPATCH;
            S_DISPATCH:
            begin
                state_next = S_OUT;
                if (op_reg == rte_pkg::OP_NEXT && cursor_reg < total_reg)
                    state_next = S_IDX_GO;
                else if (op_reg == rte_pkg::OP_INDEX && {1'b0, index_reg} < total_reg)
                    state_next = S_IDX_GO;
            end
            S_IDX_GO:
                state_next = S_IDX_WAIT;
            S_IDX_WAIT:
                if (div_done)
                    state_next = S_MUL_X;
            S_MUL_X:
                state_next = S_MUL_Y;
            S_MUL_Y:
                state_next = S_OUT;
            S_OUT:
                if (out_load)
                    state_next = S_IDLE;
            default:
                state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg         <= S_IDLE;
            image_width_reg   <= CW'(1920);
            image_height_reg  <= CW'(1080);
            tile_width_reg    <= TW'(64);
            tile_height_reg   <= TW'(64);
            region_left_reg   <= '0;
            region_top_reg    <= '0;
            region_right_reg  <= rte_pkg::RIGHT_W'(1920);
            region_bottom_reg <= rte_pkg::RIGHT_W'(1080);
            dirty_reg         <= 1'b1;
            cursor_reg        <= '0;
            step_reg          <= '0;
            hit_reg           <= 1'b0;
            out_valid_reg     <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (cfg_we)
            begin
                dirty_reg  <= 1'b1;
                cursor_reg <= '0;
                unique case (cfg_addr)
                    rte_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= cfg_data[CW-1:0];
                    rte_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= cfg_data[CW-1:0];
                    rte_pkg::REG_TILE_WIDTH:    tile_width_reg    <= cfg_data[TW-1:0];
                    rte_pkg::REG_TILE_HEIGHT:   tile_height_reg   <= cfg_data[TW-1:0];
                    rte_pkg::REG_REGION_LEFT:   region_left_reg   <= cfg_data[rte_pkg::LEFT_W-1:0];
                    rte_pkg::REG_REGION_TOP:    region_top_reg    <= cfg_data[rte_pkg::LEFT_W-1:0];
                    rte_pkg::REG_REGION_RIGHT:  region_right_reg  <= cfg_data;
                    rte_pkg::REG_REGION_BOTTOM: region_bottom_reg <= cfg_data;
                    default:                    dirty_reg         <= 1'b1;
                endcase
            end
            else
            begin
                if (state_reg == S_IDLE && in_fire)
                    step_reg <= '0;
                if (state_reg == S_CFG_WAIT && div_done)
                    step_reg <= step_reg + 1'b1;
                if (state_reg == S_TOTAL)
                    dirty_reg <= 1'b0;
                if (state_reg == S_DISPATCH)
                begin
                    hit_reg <= 1'b0;
                    unique case (op_reg)
                        rte_pkg::OP_NEXT:
                            if (cursor_reg < total_reg)
                            begin
                                hit_reg    <= 1'b1;
                                cursor_reg <= cursor_reg + 1'b1;
                            end
                        rte_pkg::OP_INDEX:
                            hit_reg <= ({1'b0, index_reg} < total_reg);
                        rte_pkg::OP_REWIND:
                            cursor_reg <= '0;
                        default:
                            hit_reg <= 1'b0;
                    endcase
                end
            end
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // Datapath registers
    always_ff @(posedge clk)
    begin
        if (in_fire)
        begin
            op_reg    <= s_axis_tuser;
            index_reg <= s_axis_tdata[rte_pkg::ID_W-1:0];
        end
        if (state_reg == S_CFG_WAIT && div_done)
        begin
            case (step_reg)
                2'd0:    first_col_reg <= div_quot[CW-1:0];
                2'd1:    col_count_reg <= div_quot[CW-1:0] - first_col_reg;
                2'd2:    first_row_reg <= div_quot[CW-1:0];
                default: row_count_reg <= div_quot[CW-1:0] - first_row_reg;
            endcase
        end
        if (state_reg == S_TOTAL)
            total_reg <= mul_p[rte_pkg::CNT_W-1:0];
        if (state_reg == S_DISPATCH)
            id_reg <= (op_reg == rte_pkg::OP_NEXT) ? cursor_reg[rte_pkg::ID_W-1:0] : index_reg;
        if (state_reg == S_IDX_WAIT && div_done)
        begin
            cx_reg <= first_col_reg + div_rem;
            cy_reg <= first_row_reg + div_quot[CW-1:0];
        end
        if (state_reg == S_MUL_X)
            lraw_reg <= mul_p[CW-1:0];
        if (state_reg == S_MUL_Y)
            traw_reg <= mul_p[CW-1:0];
        if (out_load)
        begin
            out_found_reg <= hit_reg;
            out_data_reg  <= {3'b000, total_reg, clip_b, clip_r, clip_t, clip_l, res_id};
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = out_data_reg;
    assign m_axis_tuser  = out_found_reg;

endmodule

`default_nettype wire
